// ===== rtl/core/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg: shared codes for the min tracking stack
// Opcodes and error codes of the stack control, and its memory port request type.
// ----------------------------------------------------------------------------
package mts_pkg;

    // request opcodes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // error codes reported with each result
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_POP_EMPTY  = 2'd1;
    localparam logic [1:0] ERR_PUSH_FULL  = 2'd2;

    // memory port request
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mts_mem_cmd_t;

endpackage

// ===== rtl/core/mts_ram.sv =====
// ----------------------------------------------------------------------------
// mts_ram: simple dual port stack memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mts_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  mts_pkg::mts_mem_cmd_t cmd,
    input  logic [AW-1:0]         wr_addr,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic [AW-1:0]         rd_addr,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/min_tracking_stack.sv =====
// ----------------------------------------------------------------------------
// min_tracking_stack: LIFO stack that also reports its running minimum
// Values and minimum candidates live in two memories, tops cached in flops.
// ----------------------------------------------------------------------------
// Usage:
//   slave side carries requests: s_tuser is the opcode (push, pop, query),
//   s_tdata the signed value to push. Every request gives exactly one result
//   on the master side: popped value, new top, new minimum, count, empty flag
//   and error code, all packed in m_tdata.
//   A push, a query or a failed pop goes from idle to the done state, which
//   loads the result register; a pop that removes an entry passes the read
//   state first: it reads the new tops back from the two memories, whose
//   read port is registered. One request is worked on at a time and the
//   control returns to idle before it takes the next one.
//   s_tready is high while no request is in work; a finished result sits in
//   the output register, so a new request is taken while the receiver
//   stalls, and the next result waits until the register is taken.
//   A push on a full stack is dropped with an error, a pop on an empty
//   stack is reported with an error; neither changes the stack.
//   Reset empties the stack at once (counts cleared, no memory sweep).
// ----------------------------------------------------------------------------
module min_tracking_stack #(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 32,
    localparam int CNT_W = $clog2(STACK_DEPTH + 1),
    localparam int IN_W  = ((VALUE_WIDTH + 7) / 8) * 8,
    localparam int RES_W = 3 * VALUE_WIDTH + CNT_W + 3,
    localparam int OUT_W = ((RES_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // push_value
    input  logic [1:0]       s_tuser,   // opcode
    output logic             m_tvalid,
    input  logic             m_tready,
    // popped_value, top_value, min_value, element_count, is_empty, error_code
    output logic [OUT_W-1:0] m_tdata
);

    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [CNT_W-1:0]              min_cnt_reg, min_cnt_next;
    logic signed [VALUE_WIDTH-1:0] top_reg, top_next;
    logic signed [VALUE_WIDTH-1:0] min_top_reg, min_top_next;
    logic [VALUE_WIDTH-1:0]        popped_reg, popped_next;
    logic [1:0]                    err_reg, err_next;
    logic                          min_pop_reg, min_pop_next;
    logic                          out_valid_reg, out_valid_next;
    logic [RES_W-1:0]              out_data_reg, out_data_next;

    mts_pkg::mts_mem_cmd_t         val_cmd, min_cmd;
    logic [AW-1:0]                 val_rd_addr, min_rd_addr;
    logic [VALUE_WIDTH-1:0]        val_rd_data, min_rd_data;
    logic [CNT_W-1:0]              cnt_m2, min_cnt_m2;

    logic                          accept;
    logic                          slot_free;
    logic signed [VALUE_WIDTH-1:0] push_val;
    logic [1:0]                    opcode;
    logic                          is_full;
    logic                          min_hit;
    logic                          push_min;

    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign push_val  = s_tdata[VALUE_WIDTH-1:0];
    assign opcode    = s_tuser;
    assign is_full   = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign min_hit   = (min_cnt_reg != '0) && (min_top_reg == top_reg);
    assign push_min  = (min_cnt_reg == '0) || (push_val <= min_top_reg);
    assign cnt_m2     = cnt_reg - CNT_W'(2);
    assign min_cnt_m2 = min_cnt_reg - CNT_W'(2);
    assign val_rd_addr = cnt_m2[AW-1:0];
    assign min_rd_addr = min_cnt_m2[AW-1:0];

    // memory requests issued when a request is taken
    always_comb
    begin
        val_cmd.wr_en = accept && (opcode == mts_pkg::OP_PUSH) && !is_full;
        min_cmd.wr_en = val_cmd.wr_en && push_min;
        val_cmd.rd_en = accept && (opcode == mts_pkg::OP_POP) && (cnt_reg != '0);
        min_cmd.rd_en = val_cmd.rd_en && min_hit;
    end

    mts_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_val_ram (
        .clk     (clk),
        .cmd     (val_cmd),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (push_val),
        .rd_addr (val_rd_addr),
        .rd_data (val_rd_data)
    );

    mts_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_min_ram (
        .clk     (clk),
        .cmd     (min_cmd),
        .wr_addr (min_cnt_reg[AW-1:0]),
        .wr_data (push_val),
        .rd_addr (min_rd_addr),
        .rd_data (min_rd_data)
    );

    // next state of the stack control and the result register
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        min_cnt_next   = min_cnt_reg;
        top_next       = top_reg;
        min_top_next   = min_top_reg;
        popped_next    = popped_reg;
        err_next       = err_reg;
        min_pop_next   = min_pop_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        s_tready       = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    popped_next  = '0;
                    err_next     = mts_pkg::ERR_NONE;
                    min_pop_next = 1'b0;
                    state_next   = S_DONE;
                    priority if (opcode == mts_pkg::OP_PUSH)
                    begin
                        if (is_full)
                        begin
                            err_next = mts_pkg::ERR_PUSH_FULL;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + CNT_W'(1);
                            top_next = push_val;
                            if (push_min)
                            begin
                                min_cnt_next = min_cnt_reg + CNT_W'(1);
                                min_top_next = push_val;
                            end
                        end
                    end
                    else if (opcode == mts_pkg::OP_POP)
                    begin
                        if (cnt_reg == '0)
                        begin
                            err_next = mts_pkg::ERR_POP_EMPTY;
                        end
                        else
                        begin
                            popped_next  = top_reg;
                            cnt_next     = cnt_reg - CNT_W'(1);
                            min_pop_next = min_hit;
                            if (min_hit)
                            begin
                                min_cnt_next = min_cnt_reg - CNT_W'(1);
                            end
                            state_next = S_READ;
                        end
                    end
                    else
                    begin
                        // query and the unused opcode leave the stack alone
                        state_next = S_DONE;
                    end
                end
            end

            S_READ:
            begin
                // new tops come back from the memories
                top_next = val_rd_data;
                if (min_pop_reg)
                begin
                    min_top_next = min_rd_data;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {
                        err_reg,
                        (cnt_reg == '0),
                        cnt_reg,
                        ((cnt_reg != '0) && (min_cnt_reg != '0)) ? min_top_reg
                                                                 : VALUE_WIDTH'(0),
                        (cnt_reg != '0) ? top_reg : VALUE_WIDTH'(0),
                        popped_reg
                    };
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            min_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            min_pop_reg   <= 1'b0;
            err_reg       <= mts_pkg::ERR_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            min_cnt_reg   <= min_cnt_next;
            out_valid_reg <= out_valid_next;
            min_pop_reg   <= min_pop_next;
            err_reg       <= err_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        min_top_reg  <= min_top_next;
        popped_reg   <= popped_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

    // the minimum stack never holds more entries than the value stack
    assert property (@(posedge clk) disable iff (!rst_n)
        min_cnt_reg <= cnt_reg)
        else $error("minimum count above element count");

    // count never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("element count above depth");

    // a push on a full stack leaves the count unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == mts_pkg::OP_PUSH) && is_full) |=> $stable(cnt_reg))
        else $error("dropped push changed the count");

    // a pop on a filled stack goes through the memory read
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == mts_pkg::OP_POP) && (cnt_reg != '0))
            |=> (state_reg == S_READ))
        else $error("pop skipped the top reload");

endmodule

// ===== bench/tb_min_tracking_stack.sv =====
// ----------------------------------------------------------------------------
// tb_min_tracking_stack: self-checking bench for the min tracking stack
// Drives push, pop and query requests over the stream ports, expects each
// result from a local stack model or the directed table, compares all fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_min_tracking_stack;

    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 500;
    localparam int DRAIN_CYCLES = 20;

    // opcode three has no package name, the block treats it as a query
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // idling modes
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    // one result, laid out as in m_tdata from the top bit down
    typedef struct packed {
        logic [1:0]  err;
        logic        empty;
        logic [6:0]  count;
        logic [31:0] minv;
        logic [31:0] topv;
        logic [31:0] popped;
    } stack_report_t;

    // one queued request
    typedef struct {
        logic [1:0]    op;
        logic [31:0]   value;
        bit            typed;
        stack_report_t report;
        int            mode;
    } stack_req_t;

    // one row of the directed table
    typedef struct {
        logic [1:0]    op;
        logic [31:0]   value;
        int            reps;
        bit            typed;
        stack_report_t report;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;   // push_value
    logic [1:0]   s_tuser;   // opcode
    logic         m_tvalid;
    logic         m_tready;
    // popped_value, top_value, min_value, element_count, is_empty, error_code
    logic [111:0] m_tdata;

    // predictor state
    logic signed [31:0] value_mem [DEPTH];
    logic signed [31:0] floor_mem [DEPTH];
    int unsigned        n_vals;
    int unsigned        n_floors;

    stack_req_t    req_q[$];
    stack_report_t report_q[$];
    dir_row_t      dir_rows[$];

    int  idle_mode;
    bit  hold_on;
    int  accept_cnt;
    int  mismatches;
    int  cycle_cnt;

    min_tracking_stack #(
        .STACK_DEPTH(DEPTH),
        .VALUE_WIDTH(32)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always #5 clk = ~clk;

    // build an expected report
    function automatic stack_report_t mk_report(logic [1:0] err, logic empty,
                                                logic [6:0] count, logic [31:0] minv,
                                                logic [31:0] topv, logic [31:0] popped);
        stack_report_t r;
        r.err    = err;
        r.empty  = empty;
        r.count  = count;
        r.minv   = minv;
        r.topv   = topv;
        r.popped = popped;
        return r;
    endfunction

    // apply one request to the local stack and report the state after it
    function automatic stack_report_t next_stack_report(logic [1:0] op,
                                                        logic signed [31:0] v);
        stack_report_t r;
        logic signed [31:0] t;
        r = '0;
        r.err = mts_pkg::ERR_NONE;
        if (op == mts_pkg::OP_PUSH)
        begin
            if (n_vals >= DEPTH)
            begin
                r.err = mts_pkg::ERR_PUSH_FULL;
            end
            else
            begin
                value_mem[n_vals] = v;
                n_vals++;
                // equal values go on the floor store too
                if (n_floors == 0 || v <= floor_mem[n_floors-1])
                begin
                    if (n_floors < DEPTH)
                    begin
                        floor_mem[n_floors] = v;
                        n_floors++;
                    end
                end
            end
        end
        else if (op == mts_pkg::OP_POP)
        begin
            if (n_vals == 0)
            begin
                r.err = mts_pkg::ERR_POP_EMPTY;
            end
            else
            begin
                t = value_mem[n_vals-1];
                if (n_floors > 0 && floor_mem[n_floors-1] == t)
                    n_floors--;
                n_vals--;
                r.popped = t;
            end
        end
        r.topv  = (n_vals > 0) ? value_mem[n_vals-1] : 32'd0;
        r.minv  = (n_floors > 0 && n_vals > 0) ? floor_mem[n_floors-1] : 32'd0;
        r.count = n_vals[6:0];
        r.empty = (n_vals == 0);
        return r;
    endfunction

    // queue one request
    task automatic add_req(logic [1:0] op, logic [31:0] value, bit typed,
                           stack_report_t report, int mode);
        stack_req_t q;
        q.op     = op;
        q.value  = value;
        q.typed  = typed;
        q.report = report;
        q.mode   = mode;
        req_q.push_back(q);
    endtask

    // directed table row
    task automatic add_row(logic [1:0] op, logic [31:0] value, int reps, bit typed,
                           stack_report_t report);
        dir_row_t d;
        d.op     = op;
        d.value  = value;
        d.reps   = reps;
        d.typed  = typed;
        d.report = report;
        dir_rows.push_back(d);
    endtask

    // random push value: mostly full range, some small and extreme values
    function automatic logic [31:0] pick_value();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5)
            return $urandom;
        else if (k < 8)
            return 32'($signed($urandom_range(0, 8)) - 4);
        else
            case ($urandom_range(0, 3))
                0: return 32'h7fffffff;
                1: return 32'h80000000;
                2: return 32'h00000000;
                default: return 32'hffffffff;
            endcase
    endfunction

    // random opcode for the mixed runs
    function automatic logic [1:0] pick_op();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45)
            return mts_pkg::OP_PUSH;
        else if (k < 85)
            return mts_pkg::OP_POP;
        else if (k < 95)
            return mts_pkg::OP_QUERY;
        else
            return OP_RESERVED;
    endfunction

    // directed table: extremes, every opcode, empty, full and duplicate minimum
    task automatic build_directed();
        stack_report_t z;
        z = '0;
        add_row(mts_pkg::OP_QUERY, 32'h0, 1, 1,
                mk_report(mts_pkg::ERR_NONE, 1, 0, 0, 0, 0));
        add_row(mts_pkg::OP_POP, 32'h12345678, 1, 1,
                mk_report(mts_pkg::ERR_POP_EMPTY, 1, 0, 0, 0, 0));
        add_row(OP_RESERVED, 32'hdeadbeef, 1, 1,
                mk_report(mts_pkg::ERR_NONE, 1, 0, 0, 0, 0));
        add_row(mts_pkg::OP_PUSH, 32'h7fffffff, 1, 1,
                mk_report(mts_pkg::ERR_NONE, 0, 1, 32'h7fffffff, 32'h7fffffff, 0));
        add_row(mts_pkg::OP_PUSH, 32'h80000000, 1, 1,
                mk_report(mts_pkg::ERR_NONE, 0, 2, 32'h80000000, 32'h80000000, 0));
        // duplicate of the minimum
        add_row(mts_pkg::OP_PUSH, 32'h80000000, 1, 1,
                mk_report(mts_pkg::ERR_NONE, 0, 3, 32'h80000000, 32'h80000000, 0));
        add_row(mts_pkg::OP_POP, 32'h0, 1, 1,
                mk_report(mts_pkg::ERR_NONE, 0, 2, 32'h80000000, 32'h80000000,
                          32'h80000000));
        add_row(mts_pkg::OP_POP, 32'hffffffff, 1, 1,
                mk_report(mts_pkg::ERR_NONE, 0, 1, 32'h7fffffff, 32'h7fffffff,
                          32'h80000000));
        add_row(mts_pkg::OP_PUSH, 32'hffffffff, 1, 1,
                mk_report(mts_pkg::ERR_NONE, 0, 2, 32'hffffffff, 32'hffffffff, 0));
        add_row(mts_pkg::OP_PUSH, 32'h0, 1, 1,
                mk_report(mts_pkg::ERR_NONE, 0, 3, 32'hffffffff, 32'h0, 0));
        add_row(mts_pkg::OP_QUERY, 32'hffffffff, 1, 0, z);
        add_row(mts_pkg::OP_POP, 32'h0, 3, 0, z);
        add_row(mts_pkg::OP_POP, 32'h0, 1, 1,
                mk_report(mts_pkg::ERR_POP_EMPTY, 1, 0, 0, 0, 0));
        // fill to the top, then one push too many
        add_row(mts_pkg::OP_PUSH, 32'hfffffffb, DEPTH, 0, z);
        add_row(mts_pkg::OP_PUSH, 32'h7, 1, 1,
                mk_report(mts_pkg::ERR_PUSH_FULL, 0, 7'(DEPTH), 32'hfffffffb,
                          32'hfffffffb, 0));
        add_row(OP_RESERVED, 32'h0, 1, 0, z);
        add_row(mts_pkg::OP_POP, 32'h0, DEPTH, 0, z);
        add_row(mts_pkg::OP_QUERY, 32'h0, 1, 1,
                mk_report(mts_pkg::ERR_NONE, 1, 0, 0, 0, 0));
        foreach (dir_rows[i])
            for (int j = 0; j < dir_rows[i].reps; j++)
                add_req(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed,
                        dir_rows[i].report, IDLE_NONE);
    endtask

    // random runs, mostly push bursts followed by pop bursts
    task automatic build_random();
        int n;
        int kind;
        int len;
        int mode;
        stack_report_t z;
        n = 0;
        z = '0;
        while (n < RAND_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            mode = (n / 60) % 4;
            if (kind < 4)
            begin
                len = $urandom_range(1, 20);
                for (int i = 0; i < len; i++)
                    add_req(mts_pkg::OP_PUSH, pick_value(), 0, z, mode);
                n += len;
                len = $urandom_range(1, 20);
                for (int i = 0; i < len; i++)
                    add_req(mts_pkg::OP_POP, $urandom, 0, z, mode);
                n += len;
            end
            else if (kind == 4)
            begin
                // deep run that can reach the full stack
                len = $urandom_range(40, 70);
                for (int i = 0; i < len; i++)
                    add_req(mts_pkg::OP_PUSH, pick_value(), 0, z, mode);
                for (int i = 0; i < len; i++)
                    add_req(mts_pkg::OP_POP, $urandom, 0, z, mode);
                n += 2 * len;
            end
            else if (kind < 9)
            begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    add_req(pick_op(), pick_value(), 0, z, mode);
                n += len;
            end
            else
            begin
                // noise: pops that may run past the bottom, a query and a reserved opcode
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    add_req(mts_pkg::OP_POP, $urandom, 0, z, mode);
                add_req(mts_pkg::OP_QUERY, $urandom, 0, z, mode);
                add_req(OP_RESERVED, $urandom, 0, z, mode);
                n += len + 2;
            end
        end
    endtask

    // sender: offer requests, take the accepted one into the predictor
    always @(posedge clk)
    begin
        stack_report_t r;
        int pct;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                r = next_stack_report(req_q[0].op, req_q[0].value);
                report_q.push_back(req_q[0].typed ? req_q[0].report : r);
                req_q.pop_front();
                accept_cnt <= accept_cnt + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (req_q.size() != 0)
                begin
                    idle_mode <= req_q[0].mode;
                    pct = (req_q[0].mode == IDLE_SEND) ? 64 :
                          (req_q[0].mode == IDLE_BOTH) ? 28 : 0;
                    if ($urandom_range(0, 99) < pct)
                    begin
                        s_tvalid <= 1'b0;
                    end
                    else
                    begin
                        s_tvalid <= 1'b1;
                        s_tdata  <= req_q[0].value;
                        s_tuser  <= req_q[0].op;
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls by mode, forced off during the long hold
    always @(posedge clk)
    begin
        int pct;
        if (rst_n)
        begin
            pct = (idle_mode == IDLE_RECV) ? 64 : (idle_mode == IDLE_BOTH) ? 28 : 0;
            if (hold_on)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(0, 99) >= pct);
        end
    end

    // long receiver hold so the block fills and stalls its input
    initial
    begin
        wait (accept_cnt >= 200);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (300) @(posedge clk);
        hold_on <= 1'b0;
    end

    // result checker
    always @(posedge clk)
    begin
        stack_report_t act;
        stack_report_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            act = m_tdata[105:0];
            if (report_q.size() == 0)
            begin
                $error("result with no request pending: %h", act);
                mismatches++;
            end
            else
            begin
                exp_r = report_q.pop_front();
                if (act.popped !== exp_r.popped)
                begin
                    $error("popped_value expected %0d actual %0d",
                           $signed(exp_r.popped), $signed(act.popped));
                    mismatches++;
                end
                if (act.topv !== exp_r.topv)
                begin
                    $error("top_value expected %0d actual %0d",
                           $signed(exp_r.topv), $signed(act.topv));
                    mismatches++;
                end
                if (act.minv !== exp_r.minv)
                begin
                    $error("min_value expected %0d actual %0d",
                           $signed(exp_r.minv), $signed(act.minv));
                    mismatches++;
                end
                if (act.count !== exp_r.count)
                begin
                    $error("element_count expected %0d actual %0d", exp_r.count, act.count);
                    mismatches++;
                end
                if (act.empty !== exp_r.empty)
                begin
                    $error("is_empty expected %0d actual %0d", exp_r.empty, act.empty);
                    mismatches++;
                end
                if (act.err !== exp_r.err)
                begin
                    $error("error_code expected %0d actual %0d", exp_r.err, act.err);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // reset, stimulus build and end of run
    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        hold_on    = 1'b0;
        idle_mode  = IDLE_NONE;
        accept_cnt = 0;
        mismatches = 0;
        cycle_cnt  = 0;
        n_vals     = 0;
        n_floors   = 0;
        build_directed();
        build_random();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (req_q.size() != 0 || s_tvalid || report_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && report_q.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mts_pkg.sv
rtl/core/mts_ram.sv
rtl/core/min_tracking_stack.sv
bench/tb_min_tracking_stack.sv
